/* hw/rtl/mxt_pkg.sv */
// Shared types and constants for the maximum XOR pair trie block.
// Holds default sizes and the command/status structs between controller and datapath.
// No dependencies.
package mxt_pkg;

    localparam int VALUE_W           = 32;
    localparam int DEF_MAX_WORDS     = 64;
    localparam int DEF_WORD_BITS     = 32;

    // Commands from the controller to the datapath, at most one high per cycle.
    typedef struct packed {
        logic accept;     // capture a beat and, unless the set is full, start the insert walk
        logic ins_step;   // walk one trie level, inserting
        logic walk_init;  // restart the walk at the root for the query
        logic qry_step;   // walk one trie level, querying
        logic update;     // fold the query result into the running maximum and count the word
        logic emit;       // present the result and clear the trie
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic full;       // set already holds the maximum number of words
        logic last;       // the current beat carries the last flag
        logic ins_done;   // this insert step is the final one of its walk
        logic qry_done;   // this query step is the final one of its walk
    } t_status;

endpackage

/* hw/rtl/mxt_ctrl.sv */
// Controller for the maximum XOR pair trie: sequences insert and query walks.
// Depends on mxt_pkg (t_cmd, t_status).
module mxt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output mxt_pkg::t_cmd    o_cmd,
    input  mxt_pkg::t_status i_status
);
    import mxt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_QINIT,
        S_QRY,
        S_UPD,
        S_END
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   n_busy;

    always_comb begin
        o_cmd           = '0;
        o_cmd.accept    = (r_state == S_IDLE) && start;
        o_cmd.ins_step  = (r_state == S_INS);
        o_cmd.walk_init = (r_state == S_QINIT);
        o_cmd.qry_step  = (r_state == S_QRY);
        o_cmd.update    = (r_state == S_UPD);
        o_cmd.emit      = (r_state == S_END) && i_status.last;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                // a beat beyond capacity skips the walks
                if (start) begin
                    n_state = i_status.full ? S_END : S_INS;
                end
            end
            S_INS: begin
                if (i_status.ins_done) begin
                    n_state = S_QINIT;
                end
            end
            S_QINIT: begin
                n_state = S_QRY;
            end
            S_QRY: begin
                if (i_status.qry_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = S_END;
            end
            S_END: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign busy = r_busy;

`ifndef SYNTHESIS
    a_busy_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) == !r_busy)
        else $error("busy out of step with controller state");

    a_full_skips_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_status.full) |=> (r_state == S_END))
        else $error("beat beyond capacity entered a walk");

    a_query_follows_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QINIT) |-> ($past(r_state) == S_INS))
        else $error("query started without an insert walk");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command in a cycle");
`endif

endmodule

/* hw/rtl/mxt_datapath.sv */
// Datapath for the maximum XOR pair trie: node table memory, walk registers,
// running maximum and result registers. Depends on mxt_pkg (t_cmd, t_status).
module mxt_datapath #(
    parameter int MAX_WORDS = mxt_pkg::DEF_MAX_WORDS,
    parameter int WORD_BITS = mxt_pkg::DEF_WORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [mxt_pkg::VALUE_W-1:0]  i_value,
    input  logic                         i_last_item,
    input  mxt_pkg::t_cmd                i_cmd,
    output mxt_pkg::t_status             o_status,
    output logic                         o_valid,
    output logic [mxt_pkg::VALUE_W-1:0]  o_max_xor,
    output logic                         o_overflow
);
    import mxt_pkg::*;

    localparam int NODE_COUNT = MAX_WORDS * WORD_BITS + 1;
    localparam int AW         = $clog2(NODE_COUNT);
    localparam int CW         = $clog2(NODE_COUNT + 1);
    localparam int WSW        = $clog2(MAX_WORDS + 1);
    localparam int LW         = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int EW         = 2 * AW;

    // Entry layout: {one_child, zero_child}. Node 0 is the root and lives in
    // flip-flops; table entries are read only for nodes allocated in this set,
    // each written in full when it is first linked below.
    logic [EW-1:0]        mem [NODE_COUNT];
    logic [EW-1:0]        r_rdata;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [EW-1:0]        mem_wdata;

    logic [WORD_BITS-1:0] r_word;
    logic                 r_last;
    logic [LW-1:0]        r_lvl;
    logic [AW-1:0]        r_node;
    logic                 r_cur_root;
    logic                 r_fresh;
    logic [WORD_BITS-1:0] r_acc;
    logic [AW-1:0]        r_root_zero;
    logic [AW-1:0]        r_root_one;
    logic [CW-1:0]        r_nodes_used;
    logic [WSW-1:0]       r_words_seen;
    logic [WORD_BITS-1:0] r_best;
    logic                 r_dropped;
    logic                 r_out_valid;
    logic [VALUE_W-1:0]   r_out_max;
    logic                 r_out_ovf;

    logic [LW-1:0]        n_lvl;
    logic [AW-1:0]        n_node;
    logic                 n_cur_root;
    logic                 n_fresh;
    logic [WORD_BITS-1:0] n_acc;
    logic [AW-1:0]        n_root_zero;
    logic [AW-1:0]        n_root_one;
    logic [CW-1:0]        n_nodes_used;

    logic [AW-1:0]        cur_zero;
    logic [AW-1:0]        cur_one;
    logic [AW-1:0]        keep_zero;
    logic [AW-1:0]        keep_one;
    logic [AW-1:0]        link;
    logic [AW-1:0]        want;
    logic [AW-1:0]        same;
    logic [AW-1:0]        new_node;
    logic [AW-1:0]        upd_zero;
    logic [AW-1:0]        upd_one;
    logic                 bit_v;
    logic                 lvl_zero;
    logic                 need_alloc;
    logic                 can_alloc;
    logic                 ins_fail;
    logic                 qry_stop;

    always_comb begin
        cur_zero   = r_cur_root ? r_root_zero : r_rdata[AW-1:0];
        cur_one    = r_cur_root ? r_root_one  : r_rdata[EW-1:AW];
        bit_v      = r_word[r_lvl];
        lvl_zero   = (r_lvl == '0);
        link       = bit_v ? cur_one : cur_zero;
        want       = bit_v ? cur_zero : cur_one;
        same       = bit_v ? cur_one : cur_zero;
        new_node   = r_nodes_used[AW-1:0];
        can_alloc  = (r_nodes_used < CW'(NODE_COUNT));
        need_alloc = r_fresh || (link == '0);
        ins_fail   = need_alloc && !can_alloc;
        qry_stop   = (want == '0) && (same == '0);
        // a fresh node has no children yet
        keep_zero  = r_fresh ? '0 : cur_zero;
        keep_one   = r_fresh ? '0 : cur_one;
        upd_zero   = bit_v ? keep_zero : new_node;
        upd_one    = bit_v ? new_node : keep_one;
    end

    always_comb begin
        o_status          = '0;
        o_status.full     = (r_words_seen == WSW'(MAX_WORDS));
        o_status.last     = r_last;
        o_status.ins_done = lvl_zero || ins_fail;
        o_status.qry_done = lvl_zero || qry_stop;
    end

    always_comb begin
        n_lvl        = r_lvl;
        n_node       = r_node;
        n_cur_root   = r_cur_root;
        n_fresh      = r_fresh;
        n_acc        = r_acc;
        n_root_zero  = r_root_zero;
        n_root_one   = r_root_one;
        n_nodes_used = r_nodes_used;
        mem_we       = 1'b0;
        mem_waddr    = r_node;
        mem_wdata    = {upd_one, upd_zero};
        rd_addr      = r_node;

        if (i_cmd.accept || i_cmd.walk_init) begin
            n_lvl      = LW'(WORD_BITS - 1);
            n_node     = '0;
            n_cur_root = 1'b1;
            n_fresh    = 1'b0;
            n_acc      = '0;
        end

        if (i_cmd.ins_step) begin
            n_lvl = r_lvl - LW'(1);
            if (need_alloc) begin
                if (can_alloc) begin
                    // link a new node under the current one
                    if (r_cur_root) begin
                        n_root_zero = upd_zero;
                        n_root_one  = upd_one;
                    end else begin
                        mem_we = 1'b1;
                    end
                    n_node       = new_node;
                    n_cur_root   = 1'b0;
                    n_fresh      = 1'b1;
                    n_nodes_used = r_nodes_used + CW'(1);
                end
            end else begin
                n_node     = link;
                n_cur_root = 1'b0;
                n_fresh    = 1'b0;
                rd_addr    = link;
            end
        end

        if (i_cmd.qry_step) begin
            n_lvl = r_lvl - LW'(1);
            if (want != '0) begin
                n_acc[r_lvl] = 1'b1;
                n_node       = want;
                n_cur_root   = 1'b0;
                rd_addr      = want;
            end else if (same != '0) begin
                n_node     = same;
                n_cur_root = 1'b0;
                rd_addr    = same;
            end
        end

        if (i_cmd.emit) begin
            n_root_zero  = '0;
            n_root_one   = '0;
            n_nodes_used = CW'(1);
        end
    end

    // node table: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_word <= i_value[WORD_BITS-1:0];
            r_last <= i_last_item;
        end
        r_lvl      <= n_lvl;
        r_node     <= n_node;
        r_acc      <= n_acc;
        if (i_cmd.emit) begin
            r_out_max <= VALUE_W'(r_best);
            r_out_ovf <= r_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_root   <= 1'b1;
            r_fresh      <= 1'b0;
            r_root_zero  <= '0;
            r_root_one   <= '0;
            r_nodes_used <= CW'(1);
            r_words_seen <= '0;
            r_best       <= '0;
            r_dropped    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_cur_root   <= n_cur_root;
            r_fresh      <= n_fresh;
            r_root_zero  <= n_root_zero;
            r_root_one   <= n_root_one;
            r_nodes_used <= n_nodes_used;
            r_out_valid  <= i_cmd.emit;
            if (i_cmd.accept && o_status.full) begin
                r_dropped <= 1'b1;
            end
            if (i_cmd.update) begin
                if (r_acc > r_best) begin
                    r_best <= r_acc;
                end
                r_words_seen <= r_words_seen + WSW'(1);
            end
            if (i_cmd.emit) begin
                r_words_seen <= '0;
                r_best       <= '0;
                r_dropped    <= 1'b0;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_max_xor  = r_out_max;
    assign o_overflow = r_out_ovf;

`ifndef SYNTHESIS
    a_words_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_words_seen <= WSW'(MAX_WORDS))
        else $error("word count beyond capacity");

    a_nodes_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nodes_used >= CW'(1)) && (r_nodes_used <= CW'(NODE_COUNT)))
        else $error("node count out of range");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_out_valid && (r_nodes_used == CW'(1)) && (r_words_seen == '0)))
        else $error("result beat without trie clear");

    a_fresh_not_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_fresh && r_cur_root))
        else $error("root marked as freshly allocated");

    a_no_root_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (mem_waddr != '0))
        else $error("table write to the root entry");
`endif

endmodule

/* hw/rtl/max_xor_pair_trie.sv */
// Top level of the maximum XOR pair trie block.
// Depends on mxt_pkg, mxt_ctrl and mxt_datapath.
//
// Usage:
//   Input channel: a word (i_value, low WORD_BITS bits used) and i_last_item
//   are taken at a rising edge with start high and busy low.
//   Result channel: o_valid is high for exactly one cycle with o_max_xor and
//   o_overflow; it comes only for a beat that carries i_last_item. The
//   receiver cannot stall; the result must be taken in that cycle.
//   Timing: an accepted word walks the trie once to insert it and once to
//   query it, one level per cycle, each level one node table access.
//   busy stays high through both walks, and no new word is taken until busy
//   is low again. A word that arrives with MAX_WORDS words already in the
//   set is dropped without a walk. The result beat comes in the first cycle
//   with busy low again.
//   After the result the trie, counters and maximum return to empty.
//   Reset: synchronous, active low; it empties the trie at once, with no
//   clearing pass over the node table.
module max_xor_pair_trie #(
    parameter int MAX_WORDS = mxt_pkg::DEF_MAX_WORDS,
    parameter int WORD_BITS = mxt_pkg::DEF_WORD_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [mxt_pkg::VALUE_W-1:0] i_value,
    input  logic                        i_last_item,
    output logic                        o_valid,
    output logic [mxt_pkg::VALUE_W-1:0] o_max_xor,
    output logic                        o_overflow
);
    import mxt_pkg::*;

    t_cmd    cmd;
    t_status status;

    mxt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_cmd    (cmd),
        .i_status (status)
    );

    mxt_datapath #(
        .MAX_WORDS (MAX_WORDS),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_last_item (i_last_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_max_xor   (o_max_xor),
        .o_overflow  (o_overflow)
    );

endmodule

/* tb/tb_max_xor_pair_trie.sv */
`timescale 1ns / 1ps
// Self-checking testbench for max_xor_pair_trie: sends sets of words and checks each
// set's largest pair XOR and overflow flag. Predicts with its own trie model.
// Depends on mxt_pkg and max_xor_pair_trie.
module tb_max_xor_pair_trie;

    localparam int MAX_WORDS    = 64;
    localparam int WORD_BITS    = 32;
    localparam int NODE_COUNT   = MAX_WORDS * WORD_BITS + 1;
    localparam int NODE_W       = 12;
    localparam int ITEMS_TARGET = 1600;
    localparam int DRAIN_CYCLES = 80;
    localparam int LIMIT_CYCLES = 3_000_000;

    localparam int MODE_RANDOM  = 0;
    localparam int MODE_PREFIX  = 1;
    localparam int MODE_EXTREME = 2;
    localparam int MODE_POOL    = 3;

    typedef struct {
        logic [mxt_pkg::VALUE_W-1:0] max_xor;
        logic                        overflow;
    } set_result_t;

    class max_xor_checker;
        logic [NODE_W-1:0]           zero_kid [NODE_COUNT];
        logic [NODE_W-1:0]           one_kid  [NODE_COUNT];
        int                          nodes_used;
        int                          words_held;
        logic [mxt_pkg::VALUE_W-1:0] best_xor;
        logic                        dropped;
        set_result_t                 awaited_results [$];
        int                          mismatches;
        int                          results_checked;

        function new();
            mismatches      = 0;
            results_checked = 0;
            clear_trie();
        endfunction

        function void clear_trie();
            foreach (zero_kid[i]) begin
                zero_kid[i] = '0;
                one_kid[i]  = '0;
            end
            nodes_used = 1;
            words_held = 0;
            best_xor   = '0;
            dropped    = 1'b0;
        endfunction

        function void insert_word(logic [31:0] w);
            int node;
            node = 0;
            for (int lvl = WORD_BITS - 1; lvl >= 0; lvl--) begin
                if (w[lvl]) begin
                    if (one_kid[node] == '0) begin
                        if (nodes_used >= NODE_COUNT) return;
                        one_kid[node] = NODE_W'(nodes_used);
                        nodes_used++;
                    end
                    node = int'(one_kid[node]);
                end else begin
                    if (zero_kid[node] == '0) begin
                        if (nodes_used >= NODE_COUNT) return;
                        zero_kid[node] = NODE_W'(nodes_used);
                        nodes_used++;
                    end
                    node = int'(zero_kid[node]);
                end
            end
        endfunction

        // Walk toward the opposite bit wherever that branch exists.
        function logic [31:0] best_partner_xor(logic [31:0] w);
            int                node;
            logic [NODE_W-1:0] want;
            logic [NODE_W-1:0] same;
            logic [31:0]       acc;
            node = 0;
            acc  = '0;
            for (int lvl = WORD_BITS - 1; lvl >= 0; lvl--) begin
                want = w[lvl] ? zero_kid[node] : one_kid[node];
                same = w[lvl] ? one_kid[node] : zero_kid[node];
                if (want != '0) begin
                    acc[lvl] = 1'b1;
                    node     = int'(want);
                end else if (same != '0) begin
                    node = int'(same);
                end else begin
                    break;
                end
            end
            return acc;
        endfunction

        function void take_word(logic [31:0] value, logic last);
            logic [31:0] w;
            logic [31:0] q;
            set_result_t res;
            w = (WORD_BITS >= 32) ? value : (value & ((32'h1 << WORD_BITS) - 1));
            if (words_held < MAX_WORDS) begin
                insert_word(w);
                q = best_partner_xor(w);
                if (q > best_xor) best_xor = q;
                words_held++;
            end else begin
                dropped = 1'b1;
            end
            if (last) begin
                res.max_xor  = best_xor;
                res.overflow = dropped;
                awaited_results.push_back(res);
                clear_trie();
            end
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic [31:0] got_xor, logic got_ovf);
            set_result_t exp;
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("result %h/%0b with none awaited", got_xor, got_ovf));
            end else begin
                exp = awaited_results.pop_front();
                results_checked++;
                if (got_xor !== exp.max_xor)
                    report_mismatch($sformatf("max_xor %h, predicted %h", got_xor, exp.max_xor));
                if (got_ovf !== exp.overflow)
                    report_mismatch($sformatf("overflow %b, predicted %b",
                                              got_ovf, exp.overflow));
            end
        endtask

        task flag_leftovers();
            while (awaited_results.size() != 0) begin
                report_mismatch($sformatf("result %h never arrived",
                                          awaited_results[0].max_xor));
                void'(awaited_results.pop_front());
            end
        endtask
    endclass

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        start       = 1'b0;
    logic [mxt_pkg::VALUE_W-1:0] i_value     = '0;
    logic                        i_last_item = 1'b0;
    logic                        busy;
    logic                        o_valid;
    logic [mxt_pkg::VALUE_W-1:0] o_max_xor;
    logic                        o_overflow;

    max_xor_checker xor_board = new();

    logic [31:0] set_words [$];
    int          cycle_count   = 0;
    int          words_sent    = 0;
    int          sets_sent     = 0;
    int          capacity_sets = 0;

    max_xor_pair_trie #(
        .MAX_WORDS (MAX_WORDS),
        .WORD_BITS (WORD_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .i_last_item (i_last_item),
        .o_valid     (o_valid),
        .o_max_xor   (o_max_xor),
        .o_overflow  (o_overflow)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) xor_board.check_result(o_max_xor, o_overflow);
            if (start && !busy) xor_board.take_word(i_value, i_last_item);
        end
    end

    // Hold the beat until the block takes it.
    task send_word(input logic [31:0] w, input logic last);
        start       <= 1'b1;
        i_value     <= w;
        i_last_item <= last;
        do @(posedge i_clk); while (busy);
        words_sent++;
    endtask

    // Drop start for a random gap, at times none; scramble the payload so it must be ignored.
    task idle_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 40)      n = 0;
        else if (r < 75) n = $urandom_range(1, 8);
        else if (r < 95) n = $urandom_range(9, 80);
        else             n = $urandom_range(81, 200);
        if (n > 0) begin
            start       <= 1'b0;
            i_value     <= $urandom;
            i_last_item <= 1'($urandom_range(0, 1));
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stop sending so no beat repeats, then wait out every awaited result.
    task wait_for_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (xor_board.awaited_results.size() != 0) @(posedge i_clk);
    endtask

    task play_set(input bit gapless);
        for (int i = 0; i < set_words.size(); i++) begin
            send_word(set_words[i], i == set_words.size() - 1);
            if (!gapless) idle_gap();
        end
        sets_sent++;
        if (set_words.size() > MAX_WORDS) capacity_sets++;
    endtask

    function logic [31:0] make_word(int mode, logic [31:0] prefix);
        logic [31:0] low_mask;
        case (mode)
            MODE_PREFIX: begin
                // Share a top prefix of random length so walks split at varied depths in the trie.
                low_mask = (32'h1 << $urandom_range(1, 31)) - 1;
                return (prefix & ~low_mask) | ($urandom & low_mask);
            end
            MODE_EXTREME: begin
                case ($urandom_range(0, 5))
                    0:       return 32'h0000_0000;
                    1:       return 32'hFFFF_FFFF;
                    2:       return 32'h8000_0000;
                    3:       return 32'h7FFF_FFFF;
                    4:       return 32'h0000_0001;
                    default: return 32'h1 << $urandom_range(0, 31);
                endcase
            end
            MODE_POOL: return prefix ^ 32'($urandom_range(0, 3));
            default:   return $urandom;
        endcase
    endfunction

    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) @(posedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        int          len;
        int          mode;
        logic [31:0] prefix;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed sets: lone words, full-range extremes, top bit, duplicates.
        set_words = '{32'h0000_0000};
        play_set(1'b0);
        set_words = '{32'hFFFF_FFFF};
        play_set(1'b1);
        set_words = '{32'h0000_0000, 32'hFFFF_FFFF};
        play_set(1'b1);
        set_words = '{32'h8000_0000, 32'h0000_0000};
        play_set(1'b0);
        set_words = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678};
        play_set(1'b1);
        set_words = '{32'hA5A5_A5A5, 32'hA5A5_A5A5, 32'hA5A5_A5A5};
        play_set(1'b0);
        set_words = '{32'd1, 32'd2, 32'd3, 32'd4};
        play_set(1'b1);
        set_words = '{32'h0000_0001, 32'h0000_0000};
        play_set(1'b1);
        set_words = '{32'hFFFF_0000, 32'h0000_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
        play_set(1'b0);
        wait_for_results();

        while (words_sent < ITEMS_TARGET) begin
            set_words.delete();
            case ($urandom_range(0, 99)) inside
                [0:3]:   len = $urandom_range(MAX_WORDS, MAX_WORDS + 6);
                [4:11]:  len = 1;
                default: len = $urandom_range(2, 16);
            endcase
            mode   = $urandom_range(MODE_RANDOM, MODE_POOL);
            prefix = $urandom;
            for (int k = 0; k < len; k++)
                set_words.push_back(make_word($urandom_range(0, 7) == 0 ? MODE_RANDOM : mode,
                                              prefix));
            play_set($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) wait_for_results();
        end

        start <= 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        xor_board.flag_leftovers();

        $display("Covered %0d words in %0d sets, %0d of them past capacity.",
                 words_sent, sets_sent, capacity_sets);
        $display("Checked %0d results, %0d mismatches.",
                 xor_board.results_checked, xor_board.mismatches);
        if (xor_board.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
